// ----- hdl/smfm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package smfm_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    // Register indexes of the configuration port
    localparam cfg_index_t REG_SPI_MODE    = 2'd0;
    localparam cfg_index_t REG_HALF_PERIOD = 2'd1;
    localparam cfg_index_t REG_CS_GUARD    = 2'd2;

    localparam logic [1:0]  RST_SPI_MODE    = 2'd0;
    localparam cfg_data_t   RST_HALF_PERIOD = 16'd1000;
    localparam cfg_data_t   RST_CS_GUARD    = 16'd5000;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_START    = 2'd1,
        CMD_SELECT   = 2'd2,
        CMD_DESELECT = 2'd3
    } cmd_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_P0_A  = 8'b0000_0010,
        ST_P0_B  = 8'b0000_0100,
        ST_P1_A  = 8'b0000_1000,
        ST_P1_B  = 8'b0001_0000,
        ST_G_SEL = 8'b0010_0000,
        ST_G_PRE = 8'b0100_0000,
        ST_G_PST = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] tx_byte;
        logic       miso;
    } in_item_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       miso;
    } tick_item_t;

    typedef struct packed {
        logic       sck;
        logic       mosi;
        logic       cs_n;
        logic       busy_res;
        logic [7:0] rx_byte;
        logic       rx_valid;
    } out_item_t;

    typedef struct packed {
        logic       we;
        cfg_index_t index;
        cfg_data_t  wdata;
    } cfg_write_t;

endpackage

`default_nettype wire

// ----- hdl/smfm_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface smfm_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/smfm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smfm_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire smfm_pkg::in_item_t    in_item,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output smfm_pkg::tick_item_t       push_item
);
    import smfm_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    tick_item_t item_reg;
    tick_item_t item_next;
    cmd_t       cmd_dec;

    // decode the command field
    always_comb
    begin
        unique case (in_item.mode)
            2'd1:    cmd_dec = CMD_START;
            2'd2:    cmd_dec = CMD_SELECT;
            2'd3:    cmd_dec = CMD_DESELECT;
            default: cmd_dec = CMD_TICK;
        endcase
    end

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                item_next.cmd     = cmd_dec;
                item_next.tx_byte = in_item.tx_byte;
                item_next.miso    = in_item.miso;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

// ----- hdl/smfm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smfm_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire smfm_pkg::tick_item_t  push_item,
    output logic                       pop_valid,
    input  wire logic                  pop,
    output smfm_pkg::tick_item_t       pop_item
);
    import smfm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    tick_item_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/smfm_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smfm_engine #(
    parameter int DIV_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire smfm_pkg::cfg_write_t  cfg,
    input  wire logic                  q_valid,
    input  wire smfm_pkg::tick_item_t  q_item,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output smfm_pkg::out_item_t        out_item
);
    import smfm_pkg::*;

    localparam logic [32:0] CNT_MAX = (33'd1 << DIV_WIDTH) - 33'd1;

    // n - 1, clipped to what the interval counter holds
    function automatic logic [DIV_WIDTH-1:0] interval_load(input logic [15:0] n);
        logic [32:0] v;
        v = (n == 16'd0) ? 33'd0 : 33'(n - 16'd1);
        interval_load = (v > CNT_MAX) ? CNT_MAX[DIV_WIDTH-1:0] : v[DIV_WIDTH-1:0];
    endfunction

    logic [1:0]           mode_reg,      mode_next;
    logic [15:0]          half_reg,      half_next;
    logic [15:0]          guard_reg,     guard_next;
    state_t               state_reg,     state_next;
    logic [7:0]           tx_shift_reg,  tx_shift_next;
    logic [7:0]           rx_shift_reg,  rx_shift_next;
    logic [2:0]           bit_idx_reg,   bit_idx_next;
    logic [DIV_WIDTH-1:0] tick_reg,      tick_next;
    logic                 sck_reg,       sck_next;
    logic                 sel_reg,       sel_next;
    logic [7:0]           last_rx_reg,   last_rx_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg,  out_item_next;
    logic                 rx_pulse;
    logic                 cpol;
    logic                 cpha;
    logic [15:0]          hp;

    assign cpol      = mode_reg[1];
    assign cpha      = mode_reg[0];
    assign hp        = (half_reg == 16'd0) ? 16'd1 : half_reg;
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        mode_next     = mode_reg;
        half_next     = half_reg;
        guard_next    = guard_reg;
        state_next    = state_reg;
        tx_shift_next = tx_shift_reg;
        rx_shift_next = rx_shift_reg;
        bit_idx_next  = bit_idx_reg;
        tick_next     = tick_reg;
        sck_next      = sck_reg;
        sel_next      = sel_reg;
        last_rx_next  = last_rx_reg;
        rx_pulse      = 1'b0;

        if (cfg.we)
        begin
            unique case (cfg.index)
                REG_SPI_MODE:
                begin
                    if (state_reg == ST_IDLE)
                    begin
                        mode_next = cfg.wdata[1:0];
                        sck_next  = cfg.wdata[1];
                    end
                end
                REG_HALF_PERIOD: half_next  = cfg.wdata;
                REG_CS_GUARD:    guard_next = cfg.wdata;
                default: ;
            endcase
        end

        if (q_pop)
        begin
            if (state_reg == ST_IDLE)
            begin
                unique case (q_item.cmd)
                    CMD_START:
                    begin
                        tx_shift_next = q_item.tx_byte;
                        rx_shift_next = 8'd0;
                        bit_idx_next  = 3'd7;
                        tick_next     = interval_load(hp);
                        sck_next      = cpha ? !cpol : cpol;
                        state_next    = cpha ? ST_P1_A : ST_P0_A;
                    end
                    CMD_SELECT:
                    begin
                        sel_next = 1'b0;
                        if (guard_reg != 16'd0)
                        begin
                            tick_next  = interval_load(guard_reg);
                            state_next = ST_G_SEL;
                        end
                    end
                    CMD_DESELECT:
                    begin
                        if (guard_reg == 16'd0)
                        begin
                            sel_next = 1'b1;
                        end
                        else
                        begin
                            tick_next  = interval_load(guard_reg);
                            state_next = ST_G_PRE;
                        end
                    end
                    default: ;
                endcase
            end
            else if (tick_reg != '0)
            begin
                tick_next = tick_reg - DIV_WIDTH'(1);
            end
            else
            begin
                unique case (state_reg)
                    ST_P0_A:
                    begin
                        sck_next      = !cpol;
                        rx_shift_next = {rx_shift_reg[6:0], q_item.miso};
                        tick_next     = interval_load(hp);
                        state_next    = ST_P0_B;
                    end
                    ST_P0_B:
                    begin
                        sck_next = cpol;
                        if (bit_idx_reg == 3'd0)
                        begin
                            last_rx_next = rx_shift_reg;
                            rx_pulse     = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg - 3'd1;
                            tick_next    = interval_load(hp);
                            state_next   = ST_P0_A;
                        end
                    end
                    ST_P1_A:
                    begin
                        sck_next      = cpol;
                        rx_shift_next = {rx_shift_reg[6:0], q_item.miso};
                        tick_next     = interval_load(hp);
                        state_next    = ST_P1_B;
                    end
                    ST_P1_B:
                    begin
                        if (bit_idx_reg == 3'd0)
                        begin
                            last_rx_next = rx_shift_reg;
                            rx_pulse     = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg - 3'd1;
                            sck_next     = !cpol;
                            tick_next    = interval_load(hp);
                            state_next   = ST_P1_A;
                        end
                    end
                    ST_G_PRE:
                    begin
                        sel_next   = 1'b1;
                        tick_next  = interval_load(guard_reg);
                        state_next = ST_G_PST;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
        end

        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (q_pop)
        begin
            out_valid_next         = 1'b1;
            out_item_next.sck      = sck_next;
            out_item_next.mosi     = tx_shift_next[bit_idx_next];
            out_item_next.cs_n     = sel_next;
            out_item_next.busy_res = (state_next != ST_IDLE);
            out_item_next.rx_byte  = last_rx_next;
            out_item_next.rx_valid = rx_pulse;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= RST_SPI_MODE;
            half_reg      <= RST_HALF_PERIOD;
            guard_reg     <= RST_CS_GUARD;
            state_reg     <= ST_IDLE;
            tx_shift_reg  <= 8'd0;
            rx_shift_reg  <= 8'd0;
            bit_idx_reg   <= 3'd7;
            tick_reg      <= '0;
            sck_reg       <= RST_SPI_MODE[1];
            sel_reg       <= 1'b1;
            last_rx_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            half_reg      <= half_next;
            guard_reg     <= guard_next;
            state_reg     <= state_next;
            tx_shift_reg  <= tx_shift_next;
            rx_shift_reg  <= rx_shift_next;
            bit_idx_reg   <= bit_idx_next;
            tick_reg      <= tick_next;
            sck_reg       <= sck_next;
            sel_reg       <= sel_next;
            last_rx_reg   <= last_rx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

// ----- hdl/spi_master_four_mode.sv -----
// SPI master for clock modes 0 to 3, driven one tick per input transaction.
// Every accepted input transaction is one clock tick of the serial engine and
// yields exactly one output transaction with the pin levels after that tick
// (sck, mosi, cs_n), a busy flag, the last received byte and a one-tick
// rx_valid pulse. The mode field of a tick starts a byte transfer (MSB first),
// selects the slave and waits the chip-select guard, or waits the guard,
// deselects and waits again; a command that arrives while busy is dropped.
// CPOL (spi_mode bit 1) sets the idle SCK level, CPHA (bit 0) picks whether
// MISO is sampled on the leading or trailing edge. half_period_ticks and
// cs_guard_ticks count ticks; a zero half period acts as one, and intervals
// longer than the DIV_WIDTH-bit tick counter saturate. Rate: one transaction
// per clock cycle sustained in both directions while the output is ready; an
// input reaches its output through the front classify register, two-entry
// tick queue and engine output register. The engine holds one register set
// and updates it once per popped tick, which sets the one-per-cycle figure.
// Configuration writes are registered; write them only with no
// transactions in flight. An spi_mode write is dropped while a transfer or
// guard is in progress and otherwise moves SCK to the new idle level at once.
`timescale 1ns / 1ps
`default_nettype none

module spi_master_four_mode #(
    parameter int DIV_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire smfm_pkg::cfg_index_t  cfg_index,
    input  wire smfm_pkg::cfg_data_t   cfg_wdata,
    smfm_stream_if.sink                in_ch,
    smfm_stream_if.source              out_ch
);
    import smfm_pkg::*;

    cfg_write_t cfg;
    logic       push_valid;
    logic       push_ready;
    tick_item_t push_item;
    logic       q_valid;
    logic       q_pop;
    tick_item_t q_item;
    in_item_t   in_item;
    out_item_t  out_item;

    // bundle the configuration write for the engine
    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    assign in_item.mode    = in_ch.data.mode;
    assign in_item.tx_byte = in_ch.data.tx_byte;
    assign in_item.miso    = in_ch.data.miso;

    // front: accept ticks and decode the command
    smfm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // short queue so either side can stall on its own
    smfm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    // back: serial engine, configuration registers and output register
    smfm_engine #(
        .DIV_WIDTH (DIV_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_item)
    );

    assign out_ch.data = out_item;

endmodule

`default_nettype wire

// ----- hdl/smfm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smfm_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire smfm_pkg::out_item_t  out_item
);

    // a completed byte ends the transfer on that very tick
    a_rx_done_not_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.rx_valid) |-> !out_item.busy_res
    ) else $error("rx_valid shown while still busy");

    // reset leaves nothing to deliver
    a_reset_empty: assert property (
        @(posedge clk)
        !rst_n |-> !out_valid
    ) else $error("output valid during reset");

    // a stalled output transaction holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item))
    ) else $error("output transaction changed while stalled");

endmodule

bind spi_master_four_mode smfm_checker u_smfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.data)
);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import smfm_pkg::*;

    // Width of the engine's tick counter; loaded intervals saturate here.
    localparam int          DIV_W       = 16;
    localparam int unsigned CNT_MAX     = (1 << DIV_W) - 1;
    // Index 3 is not decoded by the block; writes to it must be dropped.
    localparam cfg_index_t  REG_SPARE   = 2'd3;
    // Input transactions to send over the whole run.
    localparam int          ITEM_TARGET = 850;
    // Half period that reaches past the low byte of its register.
    localparam int unsigned LONG_TICKS  = 257;
    // Long receiver hold-off used to back the block up into its input.
    localparam int          STALL_LEN   = 300;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_wdata;

    smfm_stream_if #(.payload_t(in_item_t))  in_ch ();
    smfm_stream_if #(.payload_t(out_item_t)) out_ch ();

    spi_master_four_mode #(.DIV_WIDTH(DIV_W)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the SPI engine. It advances once per accepted input
    // transaction and yields the pin levels expected for that tick.
    // ------------------------------------------------------------------
    logic [1:0]  spi_cfg;
    logic [15:0] half_ticks;
    logic [15:0] guard_ticks;
    state_t      eng_phase;
    logic [7:0]  tx_reg;
    logic [7:0]  rx_reg;
    logic [2:0]  bit_pos;
    int unsigned countdown;
    logic        sck_lvl;
    logic        cs_lvl;
    logic [7:0]  last_byte;

    out_item_t   expected_pins[$];
    int          mismatches  = 0;
    int          items_sent  = 0;
    bit          no_gaps     = 1'b0;
    int          hold_len    = 0;

    // Ticks to count down for an interval of n ticks; the tick that loads
    // the interval is the first one.
    function automatic int unsigned interval_ticks(int unsigned n);
        int unsigned v;
        v = (n == 0) ? 0 : n - 1;
        return (v > CNT_MAX) ? CNT_MAX : v;
    endfunction

    function automatic out_item_t engine_tick(in_item_t it);
        out_item_t   r;
        int unsigned hp;
        logic        pol;
        logic        pha;
        logic        done;
        hp   = (half_ticks == 0) ? 1 : half_ticks;
        pol  = spi_cfg[1];
        pha  = spi_cfg[0];
        done = 1'b0;
        if (eng_phase == ST_IDLE)
        begin
            // Only an idle engine takes a command.
            case (cmd_t'(it.mode))
                CMD_START:
                begin
                    tx_reg    = it.tx_byte;
                    rx_reg    = '0;
                    bit_pos   = 3'd7;
                    countdown = interval_ticks(hp);
                    if (!pha)
                    begin
                        sck_lvl   = pol;
                        eng_phase = ST_P0_A;
                    end
                    else
                    begin
                        // Phase 1 drives the leading edge right away.
                        sck_lvl   = ~pol;
                        eng_phase = ST_P1_A;
                    end
                end
                CMD_SELECT:
                begin
                    cs_lvl = 1'b0;
                    if (guard_ticks != 0)
                    begin
                        countdown = interval_ticks(guard_ticks);
                        eng_phase = ST_G_SEL;
                    end
                end
                CMD_DESELECT:
                begin
                    // A zero guard releases chip select on the command tick.
                    if (guard_ticks == 0)
                        cs_lvl = 1'b1;
                    else
                    begin
                        countdown = interval_ticks(guard_ticks);
                        eng_phase = ST_G_PRE;
                    end
                end
                CMD_TICK: ;
            endcase
        end
        else if (countdown != 0)
            countdown--;
        else
        begin
            // Interval over: do its pin action on this tick.
            case (eng_phase)
                ST_P0_A:
                begin
                    sck_lvl   = ~pol;
                    rx_reg    = {rx_reg[6:0], it.miso};
                    countdown = interval_ticks(hp);
                    eng_phase = ST_P0_B;
                end
                ST_P0_B:
                begin
                    sck_lvl = pol;
                    if (bit_pos == 0)
                    begin
                        last_byte = rx_reg;
                        done      = 1'b1;
                        eng_phase = ST_IDLE;
                    end
                    else
                    begin
                        bit_pos--;
                        countdown = interval_ticks(hp);
                        eng_phase = ST_P0_A;
                    end
                end
                ST_P1_A:
                begin
                    sck_lvl   = pol;
                    rx_reg    = {rx_reg[6:0], it.miso};
                    countdown = interval_ticks(hp);
                    eng_phase = ST_P1_B;
                end
                ST_P1_B:
                begin
                    if (bit_pos == 0)
                    begin
                        last_byte = rx_reg;
                        done      = 1'b1;
                        eng_phase = ST_IDLE;
                    end
                    else
                    begin
                        bit_pos--;
                        sck_lvl   = ~pol;
                        countdown = interval_ticks(hp);
                        eng_phase = ST_P1_A;
                    end
                end
                ST_G_PRE:
                begin
                    cs_lvl    = 1'b1;
                    countdown = interval_ticks(guard_ticks);
                    eng_phase = ST_G_PST;
                end
                default: eng_phase = ST_IDLE;
            endcase
        end
        r.sck      = sck_lvl;
        r.mosi     = tx_reg[bit_pos];
        r.cs_n     = cs_lvl;
        r.busy_res = (eng_phase != ST_IDLE);
        r.rx_byte  = last_byte;
        r.rx_valid = done;
        return r;
    endfunction

    function automatic void apply_reg(cfg_index_t idx, int unsigned value);
        case (idx)
            REG_SPI_MODE:
            begin
                // Mode changes are dropped mid-operation; otherwise SCK
                // jumps to the new idle level.
                if (eng_phase == ST_IDLE)
                begin
                    spi_cfg = value[1:0];
                    sck_lvl = spi_cfg[1];
                end
            end
            REG_HALF_PERIOD: half_ticks  = value[15:0];
            REG_CS_GUARD:    guard_ticks = value[15:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Offer one tick transaction; predict its pins once it is accepted.
    task automatic send_tick(cmd_t cmd, logic [7:0] txb, logic miso);
        in_item_t it;
        int       gap;
        it.mode    = cmd;
        it.tx_byte = txb;
        it.miso    = miso;
        gap        = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        expected_pins.push_back(engine_tick(it));
        @(negedge clk);
    endtask

    // Keep ticking with random (ignored) commands until the engine is idle.
    task automatic run_until_idle();
        while (eng_phase != ST_IDLE)
            send_tick(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
    endtask

    task automatic issue(cmd_t cmd, logic [7:0] txb);
        send_tick(cmd, txb, 1'($urandom));
        run_until_idle();
    endtask

    // Stop offering and wait until every tick has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_pins.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int unsigned value);
        apply_reg(idx, value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= cfg_data_t'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(int unsigned mode, int unsigned hp, int unsigned guard);
        write_reg(REG_SPI_MODE, mode);
        write_reg(REG_HALF_PERIOD, hp);
        write_reg(REG_CS_GUARD, guard);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Tick-only transactions right after reset: pins must show reset levels.
    task automatic test_reset_state();
        repeat (3)
            send_tick(CMD_TICK, 8'($urandom), 1'($urandom));
    endtask

    // Zero half period acts as one; zero guard switches chip select on the
    // command tick and leaves the engine idle. Also cover the byte extremes.
    task automatic test_zero_intervals();
        drain();
        set_config(0, 0, 0);
        issue(CMD_SELECT, 8'h00);
        issue(CMD_START, 8'hFF);
        issue(CMD_START, 8'h00);
        issue(CMD_DESELECT, 8'hFF);
    endtask

    // Every clock mode, with redundant select and deselect carried out in full.
    task automatic test_each_mode();
        for (int m = 0; m < 4; m++)
        begin
            drain();
            set_config(m, 1, 1);
            issue(CMD_SELECT, 8'h00);
            issue(CMD_SELECT, 8'h00);
            issue(CMD_START, (m % 2) ? 8'h5A : 8'hA5);
            issue(CMD_DESELECT, 8'h00);
            issue(CMD_DESELECT, 8'h00);
        end
        // Undecoded index: nothing must change.
        drain();
        write_reg(REG_SPARE, 16'hFFFF);
        issue(CMD_START, 8'h3C);
    endtask

    // Register writes while a transfer is in progress: the mode write is
    // dropped, the new half period applies from the next loaded interval.
    task automatic test_writes_while_busy();
        drain();
        set_config(2, 3, 2);
        send_tick(CMD_START, 8'hC3, 1'b1);
        repeat (5)
            send_tick(CMD_TICK, 8'h00, 1'($urandom));
        drain();
        write_reg(REG_SPI_MODE, 1);
        write_reg(REG_HALF_PERIOD, 1);
        run_until_idle();
    endtask

    // Half period wider than one byte; run back-to-back to keep it short.
    task automatic test_long_intervals();
        drain();
        no_gaps = 1'b1;
        set_config(3, LONG_TICKS, 1);
        issue(CMD_SELECT, 8'h00);
        send_tick(CMD_START, 8'h81, 1'b0);
        repeat (4)
            send_tick(CMD_TICK, 8'h00, 1'($urandom));
        drain();
        // Shorten the rest of the transfer after the first long half period.
        write_reg(REG_HALF_PERIOD, 1);
        write_reg(REG_CS_GUARD, 0);
        run_until_idle();
        issue(CMD_DESELECT, 8'h00);
        no_gaps = 1'b0;
    endtask

    // Hold the receiver off while the sender keeps offering, so the block
    // fills up and must stall its input.
    task automatic test_output_stall();
        drain();
        set_config(0, 1, 2);
        no_gaps  = 1'b1;
        hold_len = STALL_LEN;
        send_tick(CMD_SELECT, 8'h00, 1'b0);
        repeat (60)
            send_tick(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        run_until_idle();
        no_gaps = 1'b0;
    endtask

    // Random settings per phase; within a phase mostly well-formed frames
    // (select, a few bytes, deselect), sometimes raw random commands.
    task automatic test_random_traffic();
        int unsigned hp;
        int unsigned guard;
        int          r;
        int          frames;
        while (items_sent < ITEM_TARGET)
        begin
            drain();
            r  = $urandom_range(0, 99);
            hp = (r < 10) ? 0 : (r < 75) ? $urandom_range(1, 3) : $urandom_range(4, 9);
            r  = $urandom_range(0, 99);
            guard = (r < 20) ? 0 : (r < 80) ? $urandom_range(1, 3)
                                            : $urandom_range(4, 10);
            set_config($urandom_range(0, 3), hp, guard);
            // Some phases run with no idling on either side.
            no_gaps = ($urandom_range(0, 5) == 0);
            frames  = $urandom_range(2, 6);
            while (frames > 0 && items_sent < ITEM_TARGET)
            begin
                frames--;
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(1, 8))
                        send_tick(cmd_t'($urandom_range(0, 3)), 8'($urandom),
                                  1'($urandom));
                    run_until_idle();
                end
                else
                begin
                    issue(CMD_SELECT, 8'($urandom));
                    repeat ($urandom_range(1, 4))
                    begin
                        repeat ($urandom_range(0, 2))
                            send_tick(CMD_TICK, 8'($urandom), 1'($urandom));
                        issue(CMD_START, 8'($urandom));
                    end
                    issue(CMD_DESELECT, 8'($urandom));
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: ready pattern and result checking.
    // ------------------------------------------------------------------

    // Drive ready: a requested hold-off first, else steady or random runs.
    initial
    begin
        int dur;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold_len - 1) @(negedge clk);
                hold_len = 0;
            end
            else if (no_gaps)
                out_ch.ready <= 1'b1;
            else if ($urandom_range(0, 9) < 7)
            begin
                out_ch.ready <= 1'b1;
                dur = $urandom_range(1, 12);
                repeat (dur - 1) @(negedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b0;
                dur = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40)
                                                  : $urandom_range(1, 3);
                repeat (dur - 1) @(negedge clk);
            end
        end
    end

    // Compare each output transaction against the oldest predicted tick.
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_pins.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: output transaction with nothing expected: %p",
                             $realtime, got);
            end
            else
            begin
                want = expected_pins.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch exp sck=%b mosi=%b cs_n=%b busy=%b",
                                 $realtime, want.sck, want.mosi, want.cs_n,
                                 want.busy_res,
                                 " rx=%h rxv=%b / got sck=%b mosi=%b cs_n=%b busy=%b",
                                 want.rx_byte, want.rx_valid,
                                 got.sck, got.mosi, got.cs_n, got.busy_res,
                                 " rx=%h rxv=%b", got.rx_byte, got.rx_valid);
                end
            end
        end
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #(20_000_000);
        $display("FAIL spi_master_four_mode");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_SPI_MODE;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;

        // Reset state of the shadow engine.
        spi_cfg     = RST_SPI_MODE;
        half_ticks  = RST_HALF_PERIOD;
        guard_ticks = RST_CS_GUARD;
        eng_phase   = ST_IDLE;
        tx_reg      = '0;
        rx_reg      = '0;
        bit_pos     = 3'd7;
        countdown   = 0;
        sck_lvl     = 1'b0;
        cs_lvl      = 1'b1;
        last_byte   = '0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_zero_intervals();
        test_each_mode();
        test_writes_while_busy();
        test_long_intervals();
        test_output_stall();
        test_random_traffic();

        // Let everything come back, then watch a little longer for strays.
        drain();
        repeat (10) @(negedge clk);

        if (mismatches == 0 && expected_pins.size() == 0)
            $display("PASS spi_master_four_mode");
        else
            $display("FAIL spi_master_four_mode");
        $finish;
    end

endmodule
